// File: sv/nrmc_pkg.sv
package nrmc_pkg;

    // Characters of the sentence header and the field separator.
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    // Time field bookkeeping.
    localparam int          COUNT_W     = 5;
    localparam logic [4:0]  COUNT_MAX   = 5'd16;
    localparam logic [4:0]  COUNT_KEEP  = 5'd4;
    localparam logic [4:0]  COUNT_VALID = 5'd7;
    localparam int          NIBBLES     = 4;

    // Hour conversion constants.
    localparam logic [7:0]  HALF_DAY    = 8'd12;
    localparam logic [7:0]  DIGIT_BASE  = 8'd10;
    localparam logic [7:0]  DIGIT_MAX   = 8'd9;

    // Reset value and width of the zone offset register.
    localparam int          ZONE_W      = 4;
    localparam logic [3:0]  ZONE_RESET  = 4'd4;

    // Depth of the queue between the parser and the display stage.
    localparam int          QUEUE_DEPTH = 2;
    localparam int          QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int          QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Parser phases.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_G     = 4'd1,
        PH_P     = 4'd2,
        PH_R     = 4'd3,
        PH_M     = 4'd4,
        PH_C     = 4'd5,
        PH_COMMA = 4'd6,
        PH_TIME  = 4'd7,
        PH_AFTER = 4'd8
    } phase_t;

    // One set of display digits.
    typedef struct packed {
        logic       hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
    } digits_t;

    // Digits shown after reset.
    localparam digits_t SHOWN_RESET = '{
        hour_tens:   1'b1,
        hour_ones:   4'd1,
        minute_tens: 4'd2,
        minute_ones: 4'd3
    };

endpackage

// File: sv/nrmc_front.sv
module nrmc_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    input  logic             cfg_wr_en,
    input  logic [3:0]       cfg_wr_data,
    input  logic             q_full,
    output logic             q_push,
    output nrmc_pkg::digits_t q_data
);
    import nrmc_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [3:0]           cap_reg [NIBBLES];
    digits_t              pend_reg, pend_next;
    logic [ZONE_W-1:0]    zone_reg;
    logic                 accept;
    logic                 is_comma;
    logic                 cap_we;
    logic [7:0]           hdr_char;
    logic [7:0]           hour_raw, hour_a, hour_b;
    logic [8:0]           hour_d;
    logic                 hour_big;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_comma = (s_rx_byte == CH_COMMA);

    // Expected header character for each matching phase.
    always_comb begin
        unique case (phase_reg)
            PH_G:    hdr_char = CH_G;
            PH_P:    hdr_char = CH_P;
            PH_R:    hdr_char = CH_R;
            PH_M:    hdr_char = CH_M;
            PH_C:    hdr_char = CH_C;
            default: hdr_char = CH_DOLLAR;
        endcase
    end

    // Hour conversion from the first two captured nibbles.
    always_comb begin
        hour_raw = 8'(cap_reg[0]) * DIGIT_BASE + 8'(cap_reg[1]);
        hour_a   = (hour_raw > HALF_DAY) ? hour_raw - HALF_DAY : hour_raw;
        hour_b   = (hour_a <= 8'(zone_reg)) ? hour_a + HALF_DAY : hour_a;
        hour_d   = {1'b0, hour_b} - 9'(zone_reg);
        hour_big = hour_d[8] || (hour_d[7:0] > DIGIT_MAX);
    end

    // Next phase, field count and pending digits.
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        pend_next  = pend_reg;
        cap_we     = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_IDLE, PH_G, PH_P, PH_R, PH_M, PH_C: begin
                    phase_next = (s_rx_byte == hdr_char) ? phase_t'(phase_reg + 4'd1)
                                                         : PH_IDLE;
                end
                PH_COMMA: begin
                    count_next = '0;
                    phase_next = is_comma ? PH_TIME : PH_IDLE;
                end
                PH_TIME: begin
                    if (is_comma) begin
                        count_next = '0;
                        phase_next = PH_AFTER;
                        if (count_reg > COUNT_VALID) begin
                            pend_next.hour_tens   = hour_big;
                            pend_next.hour_ones   = hour_big ? hour_d[3:0] - 4'd10
                                                             : hour_d[3:0];
                            pend_next.minute_tens = cap_reg[2];
                            pend_next.minute_ones = cap_reg[3];
                        end else begin
                            pend_next = '0;
                        end
                    end else if (count_reg < COUNT_MAX) begin
                        cap_we     = (count_reg < COUNT_KEEP);
                        count_next = count_reg + 5'd1;
                    end
                end
                PH_AFTER: begin
                    phase_next = PH_IDLE;
                end
                default: begin
                    phase_next = (s_rx_byte == CH_DOLLAR) ? PH_G : PH_IDLE;
                end
            endcase
        end
    end

    // Outputs towards the queue.
    always_comb begin
        q_push = accept && (phase_reg == PH_AFTER);
        q_data = pend_reg;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            pend_reg  <= '0;
            zone_reg  <= ZONE_RESET;
            for (int i = 0; i < NIBBLES; i++) begin
                cap_reg[i] <= '0;
            end
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (cfg_wr_en) begin
                zone_reg <= cfg_wr_data;
            end
            if (cap_we) begin
                cap_reg[count_reg[1:0]] <= s_rx_byte[3:0];
            end
        end
    end

    // The digits go to the queue only on the byte after the closing comma.
    a_push_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (phase_reg == PH_AFTER) && !q_full)
        else $error("push outside the phase after the comma");

    // The character count never passes its saturation value.
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("field count above saturation");

    // A closing comma always leads to the phase after the comma.
    a_comma_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (phase_reg == PH_TIME) && is_comma |=> phase_reg == PH_AFTER)
        else $error("comma did not close the time field");

endmodule

// File: sv/nrmc_queue.sv
module nrmc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  nrmc_pkg::digits_t push_data,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop,
    output nrmc_pkg::digits_t pop_data
);
    import nrmc_pkg::*;

    digits_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and occupancy updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Occupancy stays within the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // A push into a full queue would lose an item.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    // Pointers agree with the occupancy when the queue is empty.
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree while empty");

endmodule

// File: sv/nrmc_back.sv
module nrmc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  nrmc_pkg::digits_t q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hour_tens,
    output logic [3:0]        m_hour_ones,
    output logic [3:0]        m_minute_tens,
    output logic [3:0]        m_minute_ones
);
    import nrmc_pkg::*;

    digits_t shown_reg, shown_next;
    digits_t out_reg, out_next;
    logic    m_valid_reg, m_valid_next;
    logic    out_free;
    logic    differ;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = q_valid && out_free;
    assign differ   = (q_data != shown_reg);

    // A popped set is shown only when it differs from the digits on display.
    always_comb begin
        shown_next   = shown_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (q_pop && differ) begin
            shown_next   = q_data;
            out_next     = q_data;
            m_valid_next = 1'b1;
        end
    end

    // Control and display state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shown_reg   <= SHOWN_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            shown_reg   <= shown_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_hour_tens   = out_reg.hour_tens;
    assign m_hour_ones   = out_reg.hour_ones;
    assign m_minute_tens = out_reg.minute_tens;
    assign m_minute_ones = out_reg.minute_ones;

    // A new display item carries exactly the digits now on display.
    a_out_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && differ |=> m_valid_reg && (out_reg == shown_reg))
        else $error("shown digits and output disagree");

    // Nothing is taken from the queue while a result waits.
    a_hold_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |-> !q_pop)
        else $error("pop while output stalled");

    // An unchanged set leaves the display untouched.
    a_same_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && !differ |=> $stable(shown_reg))
        else $error("display changed on repeated digits");

endmodule

// File: sv/nmea_rmc_local_clock_parser_core.sv
// NMEA RMC local clock parser.
// Input channel s_valid/s_ready/s_rx_byte takes one received character per
// item and accepts a new character in every cycle while the internal queue
// has room. The parser matches the "$GPRMC," header, captures the time field
// up to the next comma and converts the hour to twelve-hour local time using
// the zone offset written through cfg_wr_en/cfg_wr_data (reset value 4).
// On the character that follows the closing comma the digits are queued,
// and a result item appears on m_valid with the four display digits only
// when they differ from those shown last.
// The queue entry written when that character is accepted moves into the
// output register once that register is free or its result is taken.
// Throughput: one character per cycle while the queue has room; the hour
// conversion is combinational constant multiply, add and compare logic
// in the parser.
// Reset (aresetn low, synchronous) returns the parser to idle, empties the
// queue and sets the shown digits to 1, 1, 2, 3.
// When the receiver stalls the result holds in the output register; the
// queue then fills and s_ready falls until the result is taken.
module nmea_rmc_local_clock_parser_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_hour_tens,
    output logic [3:0] m_hour_ones,
    output logic [3:0] m_minute_tens,
    output logic [3:0] m_minute_ones
);
    import nrmc_pkg::*;

    logic    q_full;
    logic    q_push;
    digits_t q_in;
    logic    q_valid;
    logic    q_pop;
    digits_t q_out;

    // Character parser and hour conversion.
    nrmc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    // Queue between parser and display stage.
    nrmc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_data  (q_out)
    );

    // Change detection and output register.
    nrmc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hour_tens   (m_hour_tens),
        .m_hour_ones   (m_hour_ones),
        .m_minute_tens (m_minute_tens),
        .m_minute_ones (m_minute_ones)
    );

endmodule

// File: test/nmea_rmc_local_clock_parser_core_tb.sv
module nmea_rmc_local_clock_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrmc_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CAP    = 5000;
    localparam int SETTLE       = 6;
    localparam int TAIL         = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int SEG_COUNT    = 6;
    localparam int SEG_ITEMS    = 170;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_DOT  = 8'h2E;

    // Header characters in order, the separating comma last.
    localparam logic [7:0] RMC_HDR [7] = '{CH_DOLLAR, CH_G, CH_P, CH_R, CH_M, CH_C, CH_COMMA};

    // Zone offset per random segment; segment three takes a random value instead.
    localparam logic [3:0] SEG_ZONE [SEG_COUNT] = '{4'd0, 4'd12, 4'd15, 4'd0, 4'd13, 4'd1};

    // One directed row: the byte and, where typed in, the result it must give.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic       has_res;
        digits_t    res;
    } stim_row_t;

    localparam int DIR_LEN = 30;
    localparam stim_row_t DIR_ROWS [DIR_LEN] = '{
        // Header broken by a dollar, which is not taken as a new start.
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_G,      1'b0, 1'b0, '0},
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_P,      1'b0, 1'b0, '0},
        // Full sentence with an eight character time field at the reset offset.
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_G,      1'b0, 1'b0, '0},
        '{CH_P,      1'b0, 1'b0, '0},
        '{CH_R,      1'b0, 1'b0, '0},
        '{CH_M,      1'b0, 1'b0, '0},
        '{CH_C,      1'b0, 1'b0, '0},
        '{CH_COMMA,  1'b0, 1'b0, '0},
        '{8'h31,     1'b0, 1'b0, '0},
        '{8'h32,     1'b0, 1'b0, '0},
        '{8'h33,     1'b0, 1'b0, '0},
        '{8'h34,     1'b0, 1'b0, '0},
        '{8'h35,     1'b0, 1'b0, '0},
        '{8'h36,     1'b0, 1'b0, '0},
        '{8'h37,     1'b0, 1'b0, '0},
        '{8'h38,     1'b0, 1'b0, '0},
        '{CH_COMMA,  1'b0, 1'b0, '0},
        '{8'hFF,     1'b1, 1'b1, '{1'b0, 4'd8, 4'd3, 4'd4}},
        // Empty time field: the digits fall to zero.
        '{CH_DOLLAR, 1'b0, 1'b0, '0},
        '{CH_G,      1'b0, 1'b0, '0},
        '{CH_P,      1'b0, 1'b0, '0},
        '{CH_R,      1'b0, 1'b0, '0},
        '{CH_M,      1'b0, 1'b0, '0},
        '{CH_C,      1'b0, 1'b0, '0},
        '{CH_COMMA,  1'b0, 1'b0, '0},
        '{CH_COMMA,  1'b0, 1'b0, '0},
        '{8'h00,     1'b1, 1'b1, '{1'b0, 4'd0, 4'd0, 4'd0}}
    };

    logic       aclk;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte     = '0;
    logic       cfg_wr_en     = 1'b0;
    logic [3:0] cfg_wr_data   = '0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic       m_hour_tens;
    logic [3:0] m_hour_ones;
    logic [3:0] m_minute_tens;
    logic [3:0] m_minute_ones;

    // Mirror of the parser state used for prediction.
    phase_t     rmc_phase      = PH_IDLE;
    logic [4:0] char_cnt       = '0;
    logic [3:0] time_nib [4]   = '{4'd0, 4'd0, 4'd0, 4'd0};
    digits_t    pending_digits = '0;
    digits_t    shown_digits   = SHOWN_RESET;
    logic [3:0] zone_hours     = ZONE_RESET;

    digits_t    due_digits [$];

    int         err_count      = 0;
    int         cycle_count    = 0;
    int         items_sent     = 0;
    int         results_seen   = 0;
    int         send_idle_pct  = 0;
    int         recv_idle_pct  = 0;
    bit         hold_req       = 1'b0;

    nmea_rmc_local_clock_parser_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hour_tens   (m_hour_tens),
        .m_hour_ones   (m_hour_ones),
        .m_minute_tens (m_minute_tens),
        .m_minute_ones (m_minute_ones)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Advances the parser mirror by one byte; returns 1 when new digits are shown.
    function automatic bit parse_rx_byte(input logic [7:0] b, output digits_t shown_out);
        bit          emitted;
        logic [31:0] hv;
        emitted   = 1'b0;
        shown_out = '0;
        case (rmc_phase)
            PH_IDLE, PH_G, PH_P, PH_R, PH_M, PH_C: begin
                rmc_phase = (b == RMC_HDR[rmc_phase]) ? phase_t'(rmc_phase + 4'd1) : PH_IDLE;
            end
            PH_COMMA: begin
                char_cnt  = '0;
                rmc_phase = (b == CH_COMMA) ? PH_TIME : PH_IDLE;
            end
            PH_TIME: begin
                if (b == CH_COMMA) begin
                    // Closing comma: convert the hour to twelve-hour local time.
                    if (char_cnt > COUNT_VALID) begin
                        hv = 32'(time_nib[0]) * 32'd10 + 32'(time_nib[1]);
                        if (hv > 32'd12) hv = hv - 32'd12;
                        if (hv <= 32'(zone_hours)) hv = hv + 32'd12;
                        hv = hv - 32'(zone_hours);
                        if (hv > 32'd9) begin
                            pending_digits.hour_tens = 1'b1;
                            hv = hv - 32'd10;
                        end else begin
                            pending_digits.hour_tens = 1'b0;
                        end
                        pending_digits.hour_ones   = hv[3:0];
                        pending_digits.minute_tens = time_nib[2];
                        pending_digits.minute_ones = time_nib[3];
                    end else begin
                        pending_digits = '0;
                    end
                    char_cnt  = '0;
                    rmc_phase = PH_AFTER;
                end else if (char_cnt < COUNT_MAX) begin
                    if (char_cnt < COUNT_KEEP) time_nib[char_cnt[1:0]] = b[3:0];
                    char_cnt = char_cnt + 5'd1;
                end
            end
            PH_AFTER: begin
                // The byte itself is not looked at; only changed digits are shown.
                if (pending_digits != shown_digits) begin
                    shown_digits = pending_digits;
                    shown_out    = shown_digits;
                    emitted      = 1'b1;
                end
                rmc_phase = PH_IDLE;
            end
            default: begin
                rmc_phase = (b == CH_DOLLAR) ? PH_G : PH_IDLE;
            end
        endcase
        return emitted;
    endfunction

    // Offers one byte, with random gaps before it, and predicts at acceptance.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input bit typed_has = 1'b0, input digits_t typed_res = '0);
        digits_t res;
        bit      got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        got = parse_rx_byte(b, res);
        if (typed) begin
            got = typed_has;
            res = typed_res;
        end
        if (got) due_digits.push_back(res);
        items_sent++;
    endtask

    // Stops offering items and waits for every expected result to arrive.
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (due_digits.size() != 0 && waited < DRAIN_CAP) begin
            @(posedge aclk);
            waited++;
        end
    endtask

    task automatic write_zone(input logic [3:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        zone_hours   = v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // One random sentence: mostly well formed, sometimes preceded by noise or
    // with a broken header, and with short, normal or long time fields.
    task automatic send_sentence();
        int         brk_at;
        int         pick;
        int         field_len;
        int         i;
        logic [7:0] ch;
        if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        end
        brk_at = ($urandom_range(99) < 10) ? $urandom_range(6) : 7;
        for (i = 0; i < 7; i++) begin
            if (i == brk_at) begin
                ch = 8'($urandom_range(255));
                if (ch == RMC_HDR[i]) ch = ch ^ 8'h01;
                send_byte(ch);
                return;
            end
            send_byte(RMC_HDR[i]);
        end
        pick = $urandom_range(99);
        if (pick < 12)      field_len = $urandom_range(7);
        else if (pick < 85) field_len = $urandom_range(10, 8);
        else                field_len = $urandom_range(20, 11);
        for (i = 0; i < field_len; i++) begin
            if ($urandom_range(99) < 85) begin
                ch = CH_ZERO + 8'($urandom_range(9));
            end else begin
                ch = 8'($urandom_range(255));
                if (ch == CH_COMMA) ch = CH_DOT;
            end
            send_byte(ch);
        end
        send_byte(CH_COMMA);
        send_byte(8'($urandom_range(255)));
    endtask

    // Result side: checks each accepted item and drives ready, with one long hold-off.
    initial begin
        int      hold_left;
        digits_t exp_d;
        hold_left = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
                if (due_digits.size() == 0) begin
                    $error("result item with no expectation waiting: %0d %0d %0d %0d",
                           m_hour_tens, m_hour_ones, m_minute_tens, m_minute_ones);
                    err_count++;
                end else begin
                    exp_d = due_digits.pop_front();
                    if (m_hour_tens !== exp_d.hour_tens) begin
                        $error("hour_tens: expected %0d, got %0d", exp_d.hour_tens, m_hour_tens);
                        err_count++;
                    end
                    if (m_hour_ones !== exp_d.hour_ones) begin
                        $error("hour_ones: expected %0d, got %0d", exp_d.hour_ones, m_hour_ones);
                        err_count++;
                    end
                    if (m_minute_tens !== exp_d.minute_tens) begin
                        $error("minute_tens: expected %0d, got %0d",
                               exp_d.minute_tens, m_minute_tens);
                        err_count++;
                    end
                    if (m_minute_ones !== exp_d.minute_ones) begin
                        $error("minute_ones: expected %0d, got %0d",
                               exp_d.minute_ones, m_minute_ones);
                        err_count++;
                    end
                end
            end
            if (hold_req && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed table, then random segments across offsets and idling.
    initial begin
        int         k;
        int         seg;
        int         seg_start;
        bit         paused;
        logic [3:0] zone_v;
        paused = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 15;
        recv_idle_pct = 67;
        for (k = 0; k < DIR_LEN; k++) begin
            send_byte(DIR_ROWS[k].rx, DIR_ROWS[k].typed, DIR_ROWS[k].has_res, DIR_ROWS[k].res);
        end

        for (seg = 0; seg < SEG_COUNT; seg++) begin
            wait_drained();
            repeat (SETTLE) @(posedge aclk);
            if (seg < 2) begin
                send_idle_pct = 15;
                recv_idle_pct = 67;
            end else if (seg < 4) begin
                send_idle_pct = 67;
                recv_idle_pct = 15;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            zone_v = (seg == 3) ? 4'($urandom_range(15)) : SEG_ZONE[seg];
            write_zone(zone_v);
            // Long receiver hold-off so that the block fills and stalls its input.
            if (seg == 1) hold_req = 1'b1;
            seg_start = items_sent;
            while (items_sent - seg_start < SEG_ITEMS) begin
                if (seg == 3 && !paused && items_sent - seg_start >= SEG_ITEMS / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_sentence();
            end
        end

        wait_drained();
        repeat (TAIL) @(posedge aclk);
        if (due_digits.size() != 0) begin
            $error("%0d expected result items never arrived", due_digits.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// File: files.f
sv/nrmc_pkg.sv
sv/nrmc_front.sv
sv/nrmc_queue.sv
sv/nrmc_back.sv
sv/nmea_rmc_local_clock_parser_core.sv
test/nmea_rmc_local_clock_parser_core_tb.sv
